/* design/suffix_rank_lcp_builder_top_defines.svh */
// Assertion helpers used by the builder top design file.
`ifndef SUFFIX_RANK_LCP_BUILDER_TOP_DEFINES_SVH
`define SUFFIX_RANK_LCP_BUILDER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SRLCP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRLCP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/srlcp_pkg.sv */
package srlcp_pkg;

   localparam int POS_W    = 12;
   localparam int BYTE_W   = 8;
   localparam int VAL_W    = 12;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 13;
   localparam int SUM_W    = 14;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 32;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DATA      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_MAX_LCP_ADDR = 2'd0;
   localparam logic [VAL_W-1:0]  MAX_LCP_RESET    = 12'd4095;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_RANK_RD,
      ST_RANK_WR,
      ST_K_RANK,
      ST_K_SFX,
      ST_K_J,
      ST_K_CMP,
      ST_K_WR,
      ST_DONE
   } st_type;

endpackage

/* design/srlcp_if.sv */
interface srlcp_req_if import srlcp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             action;
   logic [POS_W-1:0]  position;
   logic [BYTE_W-1:0] text_byte;
   logic [POS_W-1:0]  suffix_index;
   logic             is_last;

   modport source (output valid, action, position, text_byte, suffix_index, is_last,
                   input ready);
   modport sink   (input valid, action, position, text_byte, suffix_index, is_last,
                   output ready);
endinterface

interface srlcp_rsp_if import srlcp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VAL_W-1:0]    rank_value;
   logic [VAL_W-1:0]    lcp_value;

   modport source (output valid, status, rank_value, lcp_value, input ready);
   modport sink   (input valid, status, rank_value, lcp_value, output ready);
endinterface

/* design/suffix_rank_lcp_builder_top.sv */
// Suffix rank and LCP array builder.
// req_bus carries load and read beats. A load writes a text byte and a suffix
// array entry at a position and gives no result, unless it is
// marked last: then the text length becomes position plus one and the block
// builds the rank array and the Kasai LCP array, then returns one beat with
// status done. A read returns the rank and LCP at a position through the
// store read register and then the output register, or status not ready
// in the cycle after it is taken when no build has finished.
// A build runs a rank pass over the suffix array, then the Kasai pass over
// every position, comparing bytes for each one of nonzero rank, then gives
// the done beat. The text store reads two bytes at once; the others have one
// read port each. The block takes one beat at a time and is busy during
// reads and builds. rsp_bus holds its beat in an output register until
// taken; a new beat is accepted in the cycle the pending one drains.
// max_lcp sits at APB byte address 0; the user must let writes go in only
// while the block is idle, as the block itself does not enforce it.
// Synchronous reset clears the length, the built flag and max_lcp (4095);
// the stores hold whatever they held and read undefined until loaded.
module suffix_rank_lcp_builder_top
   import srlcp_pkg::*;
#(
   parameter int MAX_LEN = 4096
) (
   input  logic              clock,
   input  logic              reset,
   srlcp_req_if.sink         req_bus,
   srlcp_rsp_if.source       rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

`include "suffix_rank_lcp_builder_top_defines.svh"

   localparam int AW = $clog2(MAX_LEN);

   // stores
   logic [BYTE_W-1:0] text_mem [MAX_LEN];
   logic [VAL_W-1:0]  sfx_mem  [MAX_LEN];
   logic [VAL_W-1:0]  rank_mem [MAX_LEN];
   logic [VAL_W-1:0]  lcp_mem  [MAX_LEN];

   logic              text_we, sfx_we, rank_we, lcp_we;
   logic [AW-1:0]     text_waddr, text_ra, text_rb;
   logic [AW-1:0]     sfx_waddr, sfx_raddr, rank_waddr, rank_raddr;
   logic [AW-1:0]     lcp_waddr, lcp_raddr;
   logic [VAL_W-1:0]  sfx_wdata, rank_wdata, lcp_wdata;
   logic [BYTE_W-1:0] text_a_ff, text_b_ff;
   logic [VAL_W-1:0]  sfx_rd_ff, rank_rd_ff, lcp_rd_ff;

   st_type              state_ff, state_in;
   logic [LEN_W-1:0]    i_ff, i_in, h_ff, h_in, n_ff, n_in;
   logic [VAL_W-1:0]    j_ff, j_in, r_ff, r_in;
   logic                rm1_ok_ff, rm1_ok_in;
   logic                built_ff, built_in;
   logic                hit_ff, hit_in;
   logic [VAL_W-1:0]    max_lcp_ff, max_lcp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]    rsp_rank_ff, rsp_rank_in, rsp_lcp_ff, rsp_lcp_in;

   logic             accept, produce, pos_ok, last_i, bytes_eq, cmp_ok;
   logic [LEN_W-1:0] i_next, h_try;
   logic [VAL_W-1:0] j_cur, j_try, rm1, lcp_sat;
   logic [SUM_W-1:0] ih_sum, jh_sum;

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign pos_ok        = 32'(req_bus.position) < MAX_LEN;

   assign i_next   = i_ff + 13'd1;
   assign last_i   = (i_next == n_ff);
   assign rm1      = rank_rd_ff - 12'd1;
   assign bytes_eq = (text_a_ff == text_b_ff);
   assign j_cur    = rm1_ok_ff ? sfx_rd_ff : '0;
   assign j_try    = (state_ff == ST_K_J) ? j_cur : j_ff;
   assign h_try    = (state_ff == ST_K_CMP) ? h_ff + 13'd1 : h_ff;
   assign ih_sum   = SUM_W'(i_ff) + SUM_W'(h_try);
   assign jh_sum   = SUM_W'(j_try) + SUM_W'(h_try);
   assign cmp_ok   = (ih_sum < SUM_W'(n_ff)) && (jh_sum < SUM_W'(n_ff));
   assign lcp_sat  = (h_ff <= LEN_W'(max_lcp_ff)) ? h_ff[VAL_W-1:0] : max_lcp_ff;

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_MAX_LCP_ADDR) ? CSR_DW'(max_lcp_ff) : '0;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.rank_value = rsp_rank_ff;
   assign rsp_bus.lcp_value  = rsp_lcp_ff;

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      h_in          = h_ff;
      n_in          = n_ff;
      j_in          = j_ff;
      r_in          = r_ff;
      rm1_ok_in     = rm1_ok_ff;
      built_in      = built_ff;
      hit_in        = hit_ff;
      max_lcp_in    = max_lcp_ff;
      produce       = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_lcp_in    = rsp_lcp_ff;
      text_we       = 1'b0;
      sfx_we        = 1'b0;
      rank_we       = 1'b0;
      lcp_we        = 1'b0;
      text_waddr    = AW'(req_bus.position);
      sfx_waddr     = AW'(req_bus.position);
      sfx_wdata     = req_bus.suffix_index;
      text_ra       = AW'(ih_sum);
      text_rb       = AW'(jh_sum);
      sfx_raddr     = AW'(i_ff);
      rank_waddr    = AW'(sfx_rd_ff);
      rank_wdata    = i_ff[VAL_W-1:0];
      rank_raddr    = AW'(i_ff);
      lcp_waddr     = AW'(r_ff);
      lcp_wdata     = lcp_sat;
      lcp_raddr     = AW'(req_bus.position);

      if (psel && penable && pwrite && (paddr == CSR_MAX_LCP_ADDR)) begin
         max_lcp_in = pwdata[VAL_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_bus.action == ACT_LOAD) begin
                  if (pos_ok) begin
                     text_we = 1'b1;
                     sfx_we  = 1'b1;
                     if (req_bus.is_last) begin
                        // final entry of the LCP array is zero
                        n_in      = LEN_W'(req_bus.position) + 13'd1;
                        lcp_we    = 1'b1;
                        lcp_waddr = AW'(req_bus.position);
                        lcp_wdata = '0;
                        i_in      = '0;
                        h_in      = '0;
                        state_in  = ST_RANK_RD;
                     end
                  end
               end else if (!built_ff) begin
                  produce       = 1'b1;
                  rsp_status_in = STATUS_NOT_READY;
                  rsp_rank_in   = '0;
                  rsp_lcp_in    = '0;
               end else begin
                  rank_raddr = AW'(req_bus.position);
                  hit_in     = LEN_W'(req_bus.position) < n_ff;
                  state_in   = ST_READ_WAIT;
               end
            end
         end
         ST_READ_WAIT: begin
            produce       = 1'b1;
            rsp_status_in = STATUS_DATA;
            rsp_rank_in   = hit_ff ? rank_rd_ff : '0;
            rsp_lcp_in    = hit_ff ? lcp_rd_ff : '0;
            state_in      = ST_IDLE;
         end
         ST_RANK_RD: begin
            state_in = ST_RANK_WR;
         end
         ST_RANK_WR: begin
            // drop rank writes aimed past the store
            rank_we = 32'(sfx_rd_ff) < MAX_LEN;
            if (last_i) begin
               i_in     = '0;
               state_in = ST_K_RANK;
            end else begin
               i_in     = i_next;
               state_in = ST_RANK_RD;
            end
         end
         ST_K_RANK: begin
            state_in = ST_K_SFX;
         end
         ST_K_SFX: begin
            if (rank_rd_ff == '0) begin
               i_in     = i_next;
               state_in = last_i ? ST_DONE : ST_K_RANK;
            end else begin
               r_in      = rm1;
               rm1_ok_in = 32'(rm1) < MAX_LEN;
               sfx_raddr = AW'(rm1);
               state_in  = ST_K_J;
            end
         end
         ST_K_J: begin
            j_in     = j_cur;
            state_in = cmp_ok ? ST_K_CMP : ST_K_WR;
         end
         ST_K_CMP: begin
            if (bytes_eq) begin
               h_in     = h_try;
               state_in = cmp_ok ? ST_K_CMP : ST_K_WR;
            end else begin
               state_in = ST_K_WR;
            end
         end
         ST_K_WR: begin
            lcp_we   = rm1_ok_ff;
            h_in     = (h_ff == '0) ? '0 : h_ff - 13'd1;
            i_in     = i_next;
            state_in = last_i ? ST_DONE : ST_K_RANK;
         end
         ST_DONE: begin
            produce       = 1'b1;
            rsp_status_in = STATUS_DONE;
            rsp_rank_in   = '0;
            rsp_lcp_in    = '0;
            built_in      = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = produce || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         built_ff     <= 1'b0;
         n_ff         <= '0;
         max_lcp_ff   <= MAX_LCP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         built_ff     <= built_in;
         n_ff         <= n_in;
         max_lcp_ff   <= max_lcp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      h_ff          <= h_in;
      j_ff          <= j_in;
      r_ff          <= r_in;
      rm1_ok_ff     <= rm1_ok_in;
      hit_ff        <= hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_lcp_ff    <= rsp_lcp_in;
   end

   always_ff @(posedge clock) begin
      if (text_we) begin
         text_mem[text_waddr] <= req_bus.text_byte;
      end
      text_a_ff <= text_mem[text_ra];
      text_b_ff <= text_mem[text_rb];
   end

   always_ff @(posedge clock) begin
      if (sfx_we) begin
         sfx_mem[sfx_waddr] <= sfx_wdata;
      end
      sfx_rd_ff <= sfx_mem[sfx_raddr];
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[rank_waddr] <= rank_wdata;
      end
      rank_rd_ff <= rank_mem[rank_raddr];
   end

   always_ff @(posedge clock) begin
      if (lcp_we) begin
         lcp_mem[lcp_waddr] <= lcp_wdata;
      end
      lcp_rd_ff <= lcp_mem[lcp_raddr];
   end

   `SRLCP_ASSERT_IMP(a_accept_idle, clock, reset, accept, state_ff == ST_IDLE,
      "beat accepted while busy")
   `SRLCP_ASSERT_IMP(a_no_overwrite, clock, reset, produce, !rsp_valid_ff || rsp_bus.ready,
      "result overwrites a pending beat")
   `SRLCP_ASSERT_IMP(a_cmp_in_range, clock, reset, state_ff == ST_K_CMP,
      (SUM_W'(i_ff) + SUM_W'(h_ff)) < SUM_W'(n_ff), "prefix compare past text end")
   `SRLCP_ASSERT_NXT(a_done_beat, clock, reset, state_ff == ST_DONE,
      rsp_valid_ff && (rsp_status_ff == STATUS_DONE) && built_ff, "build done beat missing")

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import srlcp_pkg::*;

   typedef struct {
      logic              act;
      logic [POS_W-1:0]  pos;
      logic [BYTE_W-1:0] txt;
      logic [POS_W-1:0]  sfx;
      logic              last;
      bit                hold;
   } req_beat_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [VAL_W-1:0]    rank_v;
      logic [VAL_W-1:0]    lcp_v;
   } answer_type;

   typedef enum {SA_SORTED, SA_SHUFFLED, SA_JUNK} sa_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   srlcp_req_if req_if ();
   srlcp_rsp_if rsp_if ();

   suffix_rank_lcp_builder_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Mirror of the block's stores and settings.
   bit [BYTE_W-1:0] text_mem [4096];
   bit [POS_W-1:0]  sfx_mem  [4096];
   bit [VAL_W-1:0]  rank_mem [4096];
   bit [VAL_W-1:0]  lcp_mem  [4096];
   int              text_len = 0;
   bit              built = 1'b0;
   bit [VAL_W-1:0]  lcp_ceiling = MAX_LCP_RESET;

   req_beat_type load_q [$];
   answer_type   awaited_rsp [$];
   int           mismatches = 0;
   int           item_count = 0;
   int           plan_len = 0;
   int           covered_len = 0;

   bit [BYTE_W-1:0] phase_txt [4096];
   bit [POS_W-1:0]  phase_sa  [4096];

   int unsigned  req_beats = 0;
   int unsigned  req_beats_seen = 0;
   int unsigned  rsp_beats = 0;
   int unsigned  rsp_beats_seen = 0;
   bit           req_presenting = 1'b0;
   int           send_gap = 0;
   bit           send_calm = 1'b0;
   int           take_stall = 0;
   bit           take_calm = 1'b1;
   req_beat_type send_item;
   answer_type   got, want;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic void kasai_rebuild();
      int n, h, r, j;
      n = text_len;
      h = 0;
      for (int i = 0; i < n; i++)
         rank_mem[sfx_mem[i]] = VAL_W'(i);
      if (n > 0)
         lcp_mem[n-1] = '0;
      for (int i = 0; i < n; i++) begin
         r = rank_mem[i];
         if (r == 0)
            continue;
         j = sfx_mem[r-1];
         while (i + h < n && j + h < n && text_mem[i+h] == text_mem[j+h])
            h++;
         lcp_mem[r-1] = (h <= lcp_ceiling) ? VAL_W'(h) : lcp_ceiling;
         if (h > 0)
            h--;
      end
      built = 1'b1;
   endfunction

   task automatic kasai_take(input req_beat_type b);
      answer_type a;
      if (b.act == ACT_LOAD) begin
         text_mem[b.pos] = b.txt;
         sfx_mem[b.pos] = b.sfx;
         if (b.last) begin
            text_len = int'(b.pos) + 1;
            kasai_rebuild();
            a = '{STATUS_DONE, '0, '0};
            awaited_rsp.push_back(a);
         end
      end else begin
         if (!built)
            a = '{STATUS_NOT_READY, '0, '0};
         else if (int'(b.pos) < text_len)
            a = '{STATUS_DATA, rank_mem[b.pos], lcp_mem[b.pos]};
         else
            a = '{STATUS_DATA, '0, '0};
         awaited_rsp.push_back(a);
      end
   endtask

   // Request side: accept, predict.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         kasai_take('{req_if.action, req_if.position, req_if.text_byte,
                      req_if.suffix_index, req_if.is_last, 1'b0});
         req_beats++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         rsp_beats++;
         got = '{rsp_if.status, rsp_if.rank_value, rsp_if.lcp_value};
         if (awaited_rsp.size() == 0) begin
            report_mismatch($sformatf("result beat with none awaited (status %0d)",
                                      got.status));
         end else begin
            want = awaited_rsp.pop_front();
            if (got.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         got.status, want.status));
            if (got.rank_v !== want.rank_v)
               report_mismatch($sformatf("rank_value got %0d want %0d",
                                         got.rank_v, want.rank_v));
            if (got.lcp_v !== want.lcp_v)
               report_mismatch($sformatf("lcp_value got %0d want %0d",
                                         got.lcp_v, want.lcp_v));
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_presenting && req_beats != req_beats_seen) begin
            req_beats_seen = req_beats;
            req_presenting = 1'b0;
            send_gap = send_calm ? 0 : $urandom_range(0, 17);
         end
         if (!req_presenting) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (load_q.size() > 0 &&
                         (!load_q[0].hold || awaited_rsp.size() == 0)) begin
               send_item = load_q.pop_front();
               req_if.action       <= send_item.act;
               req_if.position     <= send_item.pos;
               req_if.text_byte    <= send_item.txt;
               req_if.suffix_index <= send_item.sfx;
               req_if.is_last      <= send_item.last;
               req_presenting = 1'b1;
               if ($urandom_range(0, 39) == 0)
                  send_calm = !send_calm;
            end
         end
         req_if.valid <= req_presenting;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_beats != rsp_beats_seen) begin
            rsp_beats_seen = rsp_beats;
            take_stall = take_calm ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 29) == 0)
               take_calm = !take_calm;
         end
         if (take_stall > 0) begin
            take_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic queue_beat(input logic act, input logic [POS_W-1:0] pos,
                             input logic [BYTE_W-1:0] txt, input logic [POS_W-1:0] sfx,
                             input logic last, input bit hold);
      req_beat_type b;
      b = '{act, pos, txt, sfx, last, hold};
      load_q.push_back(b);
      item_count++;
   endtask

   // Queue a full text of length n, every position loaded, last at n-1.
   task automatic queue_build(input int n, input int base, input int span,
                              input sa_kind_type kind);
      int order [$];
      int k, m, t, a, b;
      bit less;
      bit [POS_W-1:0] sw;
      for (k = 0; k < n; k++)
         phase_txt[k] = BYTE_W'(base + $urandom_range(0, span - 1));
      for (k = 0; k < n; k++)
         phase_sa[k] = POS_W'(k);
      case (kind)
         SA_JUNK: begin
            for (k = 0; k < n; k++)
               phase_sa[k] = $urandom_range(0, 1) ? POS_W'($urandom_range(0, n - 1))
                                                  : POS_W'($urandom_range(0, 4095));
         end
         SA_SHUFFLED: begin
            for (k = n - 1; k > 0; k--) begin
               m = $urandom_range(0, k);
               sw = phase_sa[k];
               phase_sa[k] = phase_sa[m];
               phase_sa[m] = sw;
            end
         end
         default: begin
            // Insertion sort of suffixes; a suffix that runs out first sorts lower.
            for (k = 1; k < n; k++) begin
               t = phase_sa[k];
               m = k;
               while (m > 0) begin
                  a = t;
                  b = phase_sa[m-1];
                  while (a < n && b < n && phase_txt[a] == phase_txt[b]) begin
                     a++;
                     b++;
                  end
                  less = (a == n) || (b < n && phase_txt[a] < phase_txt[b]);
                  if (!less)
                     break;
                  phase_sa[m] = phase_sa[m-1];
                  m--;
               end
               phase_sa[m] = POS_W'(t);
            end
         end
      endcase
      for (k = 0; k < n - 1; k++)
         order.push_back(k);
      for (k = order.size() - 1; k > 0; k--) begin
         m = $urandom_range(0, k);
         t = order[k];
         order[k] = order[m];
         order[m] = t;
      end
      foreach (order[k]) begin
         // Overwrite a stale load now and then.
         if ($urandom_range(0, 7) == 0)
            queue_beat(ACT_LOAD, POS_W'(order[k]), BYTE_W'($urandom),
                       POS_W'($urandom), 1'b0, 1'b0);
         queue_beat(ACT_LOAD, POS_W'(order[k]), phase_txt[order[k]],
                    phase_sa[order[k]], 1'b0, 1'b0);
      end
      queue_beat(ACT_LOAD, POS_W'(n - 1), phase_txt[n-1], phase_sa[n-1], 1'b1, 1'b0);
      plan_len = n;
      if (kind != SA_JUNK && n > covered_len)
         covered_len = n;
   endtask

   task automatic queue_reads(input int count, input bit hold_first);
      int p, sel;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(0, 9);
         if (sel < 8)
            p = $urandom_range(0, plan_len - 1);
         else if (sel == 8 && plan_len < 4096)
            p = $urandom_range(plan_len, 4095);
         else
            p = $urandom_range(0, 4095);
         queue_beat(ACT_READ, POS_W'(p), BYTE_W'($urandom), POS_W'($urandom),
                    1'($urandom), hold_first && k == 0);
      end
   endtask

   // Drain everything, then give any resultless load time to finish.
   task automatic settle();
      while (load_q.size() > 0 || req_presenting || awaited_rsp.size() > 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(input logic [VAL_W-1:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_MAX_LCP_ADDR;
      csr_pwdata  <= {{(CSR_DW-VAL_W){1'b0}}, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      lcp_ceiling = v;
      @(negedge clock);
      csr_psel    <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {{(CSR_DW-VAL_W){1'b0}}, v})
         report_mismatch($sformatf("max_lcp readback got %0d want %0d", csr_prdata, v));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int n, base, span, rand_start, pick, strays;
      sa_kind_type kind;
      req_if.valid = 1'b0;
      req_if.action = ACT_LOAD;
      req_if.position = '0;
      req_if.text_byte = '0;
      req_if.suffix_index = '0;
      req_if.is_last = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reads before any build report not ready.
      queue_beat(ACT_READ, '0, '0, '0, 1'b0, 1'b0);
      queue_beat(ACT_READ, '1, '1, '1, 1'b1, 1'b0);
      settle();
      csr_write(MAX_LCP_RESET);
      // Single-byte text, then reads in and past the length.
      queue_build(1, 0, 1, SA_SORTED);
      queue_beat(ACT_READ, POS_W'(0), '0, '0, 1'b0, 1'b1);
      queue_beat(ACT_READ, POS_W'(1), '0, '0, 1'b0, 1'b0);
      // One repeated byte gives the longest prefixes.
      queue_build(6, 8'hFF, 1, SA_SORTED);
      queue_beat(ACT_READ, POS_W'(0), '0, '0, 1'b0, 1'b0);
      queue_beat(ACT_READ, POS_W'(3), '0, '0, 1'b0, 1'b0);
      queue_beat(ACT_READ, POS_W'(5), '0, '0, 1'b0, 1'b0);
      queue_beat(ACT_READ, POS_W'(6), '0, '0, 1'b0, 1'b0);
      // A load after the build leaves the results in place.
      queue_beat(ACT_LOAD, '1, '1, '1, 1'b0, 1'b0);
      queue_beat(ACT_READ, '1, '0, '0, 1'b0, 1'b0);
      queue_beat(ACT_READ, POS_W'(0), '0, '0, 1'b0, 1'b0);
      settle();
      csr_write(VAL_W'(2));
      queue_build(6, 8'h41, 1, SA_SORTED);
      queue_reads(3, 1'b1);
      settle();
      csr_write('0);

      rand_start = item_count;
      while (item_count - rand_start < 900) begin
         if ($urandom_range(0, 2) == 0) begin
            settle();
            case ($urandom_range(0, 5))
               0: csr_write('0);
               1: csr_write('1);
               2: csr_write(VAL_W'(1));
               3: csr_write(VAL_W'(2));
               4: csr_write(VAL_W'($urandom_range(0, 7)));
               default: csr_write(VAL_W'($urandom_range(0, 4095)));
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 85)
            n = $urandom_range(1, 24);
         else if (pick < 97)
            n = $urandom_range(25, 64);
         else
            n = $urandom_range(100, 160);
         pick = $urandom_range(0, 9);
         if (pick < 7)
            kind = SA_SORTED;
         else if (pick < 9 || n > covered_len)
            kind = SA_SHUFFLED;
         else
            kind = SA_JUNK;
         base = $urandom_range(0, 255);
         case ($urandom_range(0, 3))
            0: span = $urandom_range(1, 2);
            1: span = $urandom_range(3, 4);
            2: begin
               base = 0;
               span = 256;
            end
            default: span = $urandom_range(1, 26);
         endcase
         queue_build(n, base, span, kind);
         queue_reads($urandom_range(1, (n < 19) ? 2 * n + 2 : 40),
                     $urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1)) begin
            strays = $urandom_range(1, 4);
            repeat (strays)
               queue_beat(ACT_LOAD, POS_W'($urandom), BYTE_W'($urandom),
                          POS_W'($urandom), 1'b0, 1'b0);
            queue_reads($urandom_range(1, 6), 1'b0);
         end
      end

      settle();
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
